FILE: hw/rtl/phase_modulation_voice_top_macros.svh
// Assertion macros shared by the phase modulation voice checkers.
`ifndef PHASE_MODULATION_VOICE_TOP_MACROS_SVH
`define PHASE_MODULATION_VOICE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PMV_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PMV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/pmv_pkg.sv
// Package: widths, codes, microcode program and sine table builder.
package pmv_pkg;

  // Field widths
  localparam int SAMPLE_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int INDEX_W     = 16;
  localparam int PSTEP_W     = 31;
  localparam int PHASE_W     = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 31;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_GAIN   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MODULATOR_GAIN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOD_INDEX      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_STEP      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_STEP       = 3'd4;

  // Register reset values
  localparam logic [GAIN_W-1:0]  RST_CARRIER_GAIN   = 16'd65535;
  localparam logic [GAIN_W-1:0]  RST_MODULATOR_GAIN = 16'd65535;
  localparam logic [INDEX_W-1:0] RST_MOD_INDEX      = 16'd4096;
  localparam logic [PSTEP_W-1:0] RST_BASE_STEP      = 31'd39370534;
  localparam logic [PSTEP_W-1:0] RST_MIN_STEP       = 31'd895;

  // Limits and scale constants
  localparam logic [INDEX_W-1:0] MIN_INDEX   = 16'd41;
  localparam logic [INDEX_W-1:0] MAX_INDEX   = 16'd40960;
  localparam logic [PSTEP_W-1:0] MAX_STEP    = 31'd1932735283;
  localparam logic [29:0]        INV_TWO_PI  = 30'd683565276;
  localparam logic [63:0]        PI_HALF_Q30 = 64'd1686629713;

  // Shared multiplier
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 31;
  localparam int PROD_W  = 63;

  // Microcode fields
  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;
  typedef logic [2:0]      a_sel_t;
  typedef logic [2:0]      b_sel_t;
  typedef logic [2:0]      wb_t;
  typedef logic [1:0]      seq_t;

  localparam a_sel_t A_ZERO      = 3'd0;
  localparam a_sel_t A_MOD_IN    = 3'd1;
  localparam a_sel_t A_MOD_INDEX = 3'd2;
  localparam a_sel_t A_BASE_STEP = 3'd3;
  localparam a_sel_t A_MOD_R     = 3'd4;
  localparam a_sel_t A_IM_R      = 3'd5;
  localparam a_sel_t A_CAR_IN    = 3'd6;
  localparam a_sel_t A_CAR_R     = 3'd7;

  localparam b_sel_t B_ZERO  = 3'd0;
  localparam b_sel_t B_MG    = 3'd1;
  localparam b_sel_t B_CIDX  = 3'd2;
  localparam b_sel_t B_CFRQ  = 3'd3;
  localparam b_sel_t B_IDX_R = 3'd4;
  localparam b_sel_t B_CG    = 3'd5;
  localparam b_sel_t B_INV   = 3'd6;
  localparam b_sel_t B_SINE  = 3'd7;

  localparam wb_t WB_NONE = 3'd0;
  localparam wb_t WB_MOD  = 3'd1;
  localparam wb_t WB_IDX  = 3'd2;
  localparam wb_t WB_STEP = 3'd3;
  localparam wb_t WB_IM   = 3'd4;
  localparam wb_t WB_CAR  = 3'd5;
  localparam wb_t WB_OFF  = 3'd6;
  localparam wb_t WB_OUT  = 3'd7;

  localparam seq_t SEQ_NEXT     = 2'd0;
  localparam seq_t SEQ_WAIT_IN  = 2'd1;
  localparam seq_t SEQ_WAIT_OUT = 2'd2;
  localparam seq_t SEQ_JUMP     = 2'd3;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   mul_en;
    wb_t    wb;
    seq_t   seq;
    pc_t    target;
  } ctrl_t;

  // Status fed back to the sequencer for its conditional jumps
  typedef struct packed {
    logic in_fire;
    logic out_free;
  } seq_stat_t;

  function automatic ctrl_t cw(a_sel_t a, b_sel_t b, logic m, wb_t w, seq_t s, pc_t t);
    ctrl_t c;
    c.a_sel  = a;
    c.b_sel  = b;
    c.mul_en = m;
    c.wb     = w;
    c.seq    = s;
    c.target = t;
    return c;
  endfunction

  // Program: each multiply lands in the product register, the next step writes it back.
  function automatic ctrl_t ucode(pc_t pc);
    ctrl_t c;
    case (pc)
      4'd0: c = cw(A_ZERO,      B_ZERO,  1'b0, WB_NONE, SEQ_WAIT_IN,  4'd1);
      4'd1: c = cw(A_MOD_IN,    B_MG,    1'b1, WB_NONE, SEQ_NEXT,     4'd0);
      4'd2: c = cw(A_MOD_INDEX, B_CIDX,  1'b1, WB_MOD,  SEQ_NEXT,     4'd0);
      4'd3: c = cw(A_BASE_STEP, B_CFRQ,  1'b1, WB_IDX,  SEQ_NEXT,     4'd0);
      4'd4: c = cw(A_MOD_R,     B_IDX_R, 1'b1, WB_STEP, SEQ_NEXT,     4'd0);
      4'd5: c = cw(A_CAR_IN,    B_CG,    1'b1, WB_IM,   SEQ_NEXT,     4'd0);
      4'd6: c = cw(A_IM_R,      B_INV,   1'b1, WB_CAR,  SEQ_NEXT,     4'd0);
      4'd7: c = cw(A_ZERO,      B_ZERO,  1'b0, WB_OFF,  SEQ_NEXT,     4'd0);
      4'd8: c = cw(A_CAR_R,     B_SINE,  1'b1, WB_NONE, SEQ_NEXT,     4'd0);
      4'd9: c = cw(A_ZERO,      B_ZERO,  1'b0, WB_OUT,  SEQ_WAIT_OUT, 4'd0);
      default: c = cw(A_ZERO,   B_ZERO,  1'b0, WB_NONE, SEQ_JUMP,     4'd0);
    endcase
    return c;
  endfunction

  // Unsigned quotient by shift and subtract, for the table build
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine entry k: Taylor series in Q30, scaled to the sample amplitude.
  function automatic logic [63:0] sine_entry(int unsigned k, int unsigned tbits,
                                             int unsigned sbits);
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        amp;
    logic signed [63:0] sum;
    x    = (PI_HALF_Q30 * 64'(k)) >> tbits;
    term = x;
    sum  = $signed(x);
    amp  = (64'd1 << (sbits - 1)) - 64'd1;
    for (int i = 1; i <= 13; i++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = udiv64(term, 64'(2 * i) * 64'(2 * i + 1));
      if ((i & 1) != 0) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    return ($unsigned(sum) * amp + (64'd1 << 29)) >> 30;
  endfunction

endpackage

FILE: hw/rtl/pmv_if.sv
// Valid/ready channel interfaces for the input items and the result samples.
interface pmv_in_if import pmv_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] carrier_sample;
  logic signed [SAMPLE_W-1:0] modulator_sample;
  logic signed [SAMPLE_W-1:0] ctl_carrier_gain;
  logic signed [SAMPLE_W-1:0] ctl_modulator_gain;
  logic signed [SAMPLE_W-1:0] ctl_index;
  logic signed [SAMPLE_W-1:0] ctl_frequency;

  modport source (output valid, carrier_sample, modulator_sample, ctl_carrier_gain,
                  ctl_modulator_gain, ctl_index, ctl_frequency, input ready);
  modport sink   (input valid, carrier_sample, modulator_sample, ctl_carrier_gain,
                  ctl_modulator_gain, ctl_index, ctl_frequency, output ready);
endinterface

interface pmv_out_if import pmv_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_sample;

  modport source (output valid, out_sample, input ready);
  modport sink   (input valid, out_sample, output ready);
endinterface

FILE: hw/rtl/phase_modulation_voice_top.sv
// Phase modulation voice: top level with config registers and shared-multiplier datapath.
// A result reaches the output register at the last step, once the item has passed through
// the microcode's seven products on the one shared multiplier plus the sine ROM read.
// A new item is taken only after that result is loaded; a stalled output holds the sequencer.
// Reset: synchronous active-low rst_n restarts the sequencer, clears the phase and loads defaults.
module phase_modulation_voice_top import pmv_pkg::*; #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  pmv_in_if.sink                 in_ch,
  pmv_out_if.source              out_ch
);

  localparam int OFF_SHIFT = 27;
  localparam int Y_W       = 18;

  // Config registers
  logic [GAIN_W-1:0]  carrier_gain_r;
  logic [GAIN_W-1:0]  modulator_gain_r;
  logic [INDEX_W-1:0] mod_index_r;
  logic [PSTEP_W-1:0] base_step_r;
  logic [PSTEP_W-1:0] min_step_r;

  // Captured item
  logic signed [SAMPLE_W-1:0] car_in_r;
  logic signed [SAMPLE_W-1:0] mod_in_r;
  logic [SAMPLE_W-1:0]        cidx_r;
  logic [SAMPLE_W-1:0]        cfrq_r;
  logic [GAIN_W-1:0]          cg_r;
  logic [GAIN_W-1:0]          mg_r;

  // Intermediate results
  logic signed [SAMPLE_W-1:0] mod_r;
  logic signed [SAMPLE_W-1:0] car_r;
  logic [INDEX_W-1:0]         idx_r;
  logic [INDEX_W-1:0]         idx_nxt;
  logic [PSTEP_W-1:0]         pstep_r;
  logic [PSTEP_W-1:0]         pstep_nxt;
  logic signed [31:0]         im_r;
  logic [PHASE_W-1:0]         acc_r;
  logic [PHASE_W-1:0]         ph_nxt;

  // Multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  prod_r;

  // Output
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic signed [SAMPLE_W-1:0] sample_nxt;
  logic signed [Y_W-1:0]      y_wide;
  logic signed [SAMPLE_BITS-1:0] sine;

  ctrl_t     ctrl;
  seq_stat_t stat;
  logic      in_fire;
  logic      out_free;
  logic      out_load;
  logic [17:0] idx_raw;
  logic [31:0] pstep_raw;
  logic [PSTEP_W-1:0] pstep_lo;

  function automatic logic [GAIN_W-1:0] offset_gain(logic [GAIN_W-1:0] base,
                                                    logic signed [SAMPLE_W-1:0] c);
    logic signed [17:0] g;
    g = $signed({2'b00, base}) + $signed({c[SAMPLE_W-1], c, 1'b0});
    if (g < 0) begin
      return '0;
    end else if (g > 18'sd65535) begin
      return '1;
    end
    return g[GAIN_W-1:0];
  endfunction

  // Sequencer
  assign in_fire        = in_ch.valid && in_ch.ready;
  assign out_free       = !out_valid_r || out_ch.ready;
  assign out_load       = (ctrl.wb == WB_OUT) && out_free;
  assign stat.in_fire   = in_fire;
  assign stat.out_free  = out_free;
  assign in_ch.ready    = (ctrl.seq == SEQ_WAIT_IN);

  pmv_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_gain_r   <= RST_CARRIER_GAIN;
      modulator_gain_r <= RST_MODULATOR_GAIN;
      mod_index_r      <= RST_MOD_INDEX;
      base_step_r      <= RST_BASE_STEP;
      min_step_r       <= RST_MIN_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CARRIER_GAIN:   carrier_gain_r   <= cfg_data[GAIN_W-1:0];
        CFG_MODULATOR_GAIN: modulator_gain_r <= cfg_data[GAIN_W-1:0];
        CFG_MOD_INDEX:      mod_index_r      <= cfg_data[INDEX_W-1:0];
        CFG_BASE_STEP:      base_step_r      <= cfg_data[PSTEP_W-1:0];
        CFG_MIN_STEP:       min_step_r       <= cfg_data[PSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the item; gains are offset and clamped here, 1+c becomes c with MSB flipped
  always_ff @(posedge clk) begin
    if (in_fire) begin
      car_in_r <= in_ch.carrier_sample;
      mod_in_r <= in_ch.modulator_sample;
      cidx_r   <= {~in_ch.ctl_index[SAMPLE_W-1], in_ch.ctl_index[SAMPLE_W-2:0]};
      cfrq_r   <= {~in_ch.ctl_frequency[SAMPLE_W-1], in_ch.ctl_frequency[SAMPLE_W-2:0]};
      cg_r     <= offset_gain(carrier_gain_r, in_ch.ctl_carrier_gain);
      mg_r     <= offset_gain(modulator_gain_r, in_ch.ctl_modulator_gain);
    end
  end

  // Operand selection
  always_comb begin
    case (ctrl.a_sel)
      A_MOD_IN:    mul_a = MUL_A_W'(mod_in_r);
      A_MOD_INDEX: mul_a = $signed(MUL_A_W'(mod_index_r));
      A_BASE_STEP: mul_a = $signed(MUL_A_W'(base_step_r));
      A_MOD_R:     mul_a = MUL_A_W'(mod_r);
      A_IM_R:      mul_a = im_r;
      A_CAR_IN:    mul_a = MUL_A_W'(car_in_r);
      A_CAR_R:     mul_a = MUL_A_W'(car_r);
      default:     mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.b_sel)
      B_MG:    mul_b = $signed(MUL_B_W'(mg_r));
      B_CIDX:  mul_b = $signed(MUL_B_W'(cidx_r));
      B_CFRQ:  mul_b = $signed(MUL_B_W'(cfrq_r));
      B_IDX_R: mul_b = $signed(MUL_B_W'(idx_r));
      B_CG:    mul_b = $signed(MUL_B_W'(cg_r));
      B_INV:   mul_b = $signed(MUL_B_W'(INV_TWO_PI));
      B_SINE:  mul_b = MUL_B_W'(sine);
      default: mul_b = '0;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // Index: (mod_index * (1 + c)) >> 15, clamped
  assign idx_raw = prod_r[32:15];
  always_comb begin
    if (idx_raw < 18'(MIN_INDEX)) begin
      idx_nxt = MIN_INDEX;
    end else if (idx_raw > 18'(MAX_INDEX)) begin
      idx_nxt = MAX_INDEX;
    end else begin
      idx_nxt = idx_raw[INDEX_W-1:0];
    end
  end

  // Phase step: raised to the minimum first, the maximum wins last
  assign pstep_raw = prod_r[46:15];
  assign pstep_lo  = (pstep_raw < 32'(min_step_r)) ? min_step_r : pstep_raw[PSTEP_W-1:0];
  always_comb begin
    if ((pstep_raw >= 32'(min_step_r)) && (pstep_raw > 32'(MAX_STEP))) begin
      pstep_nxt = MAX_STEP;
    end else if (pstep_lo > MAX_STEP) begin
      pstep_nxt = MAX_STEP;
    end else begin
      pstep_nxt = pstep_lo;
    end
  end

  // Write back results of the previous product
  always_ff @(posedge clk) begin
    case (ctrl.wb)
      WB_MOD:  mod_r   <= prod_r[31:16];
      WB_IDX:  idx_r   <= idx_nxt;
      WB_STEP: pstep_r <= pstep_nxt;
      WB_IM:   im_r    <= prod_r[31:0];
      WB_CAR:  car_r   <= prod_r[31:16];
      default: ;
    endcase
  end

  // Modulated phase: accumulator plus the wrapped offset, feeds the ROM address
  assign ph_nxt = acc_r + prod_r[OFF_SHIFT+PHASE_W-1:OFF_SHIFT];

  pmv_sine_rom #(
    .TABLE_BITS  (SINE_TABLE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sine_rom (
    .clk      (clk),
    .rd_en    (ctrl.wb == WB_OFF),
    .phase_hi (ph_nxt[PHASE_W-1:PHASE_W-SINE_TABLE_BITS-2]),
    .sine     (sine)
  );

  // Output scaling and saturation
  assign y_wide = prod_r[SAMPLE_BITS+Y_W-2:SAMPLE_BITS-1];
  always_comb begin
    if (y_wide > 18'sd32767) begin
      sample_nxt = 16'sh7fff;
    end else if (y_wide < -18'sd32768) begin
      sample_nxt = 16'sh8000;
    end else begin
      sample_nxt = y_wide[SAMPLE_W-1:0];
    end
  end

  // Output register and phase accumulator advance on result load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      acc_r       <= acc_r + PHASE_W'(pstep_r);
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= sample_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_sample = out_sample_r;

endmodule

FILE: hw/rtl/pmv_seq.sv
// Microcode sequencer: step counter, program lookup and conditional jumps.
module pmv_seq import pmv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t stat,
  output ctrl_t     ctrl
);

  pc_t pc_r;
  pc_t pc_nxt;

  assign ctrl = ucode(pc_r);

  // Next step: advance, jump, or hold on a wait that is not met
  always_comb begin
    case (ctrl.seq)
      SEQ_NEXT:     pc_nxt = pc_r + 1'b1;
      SEQ_WAIT_IN:  pc_nxt = stat.in_fire  ? ctrl.target : pc_r;
      SEQ_WAIT_OUT: pc_nxt = stat.out_free ? ctrl.target : pc_r;
      SEQ_JUMP:     pc_nxt = ctrl.target;
      default:      pc_nxt = ctrl.target;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: hw/rtl/pmv_sine_rom.sv
// Quarter-wave sine ROM with registered read and quadrant folding.
module pmv_sine_rom import pmv_pkg::*; #(
  parameter int TABLE_BITS  = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [TABLE_BITS+1:0]         phase_hi,
  output logic signed [SAMPLE_BITS-1:0] sine
);

  localparam int N      = 1 << TABLE_BITS;
  localparam int DEPTH  = N + 1;
  localparam int ADDR_W = TABLE_BITS + 1;
  localparam int DATA_W = SAMPLE_BITS - 1;

  typedef logic [DATA_W-1:0] word_t;
  typedef word_t rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < DEPTH; k++) begin
      r[k] = DATA_W'(sine_entry(k, TABLE_BITS, SAMPLE_BITS));
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [1:0]                    quad;
  logic [TABLE_BITS-1:0]         fine;
  logic [ADDR_W-1:0]             addr;
  word_t                         data_r;
  logic                          neg_r;
  logic signed [SAMPLE_BITS-1:0] mag;

  // Odd quadrants read the table mirrored
  assign quad = phase_hi[TABLE_BITS+1:TABLE_BITS];
  assign fine = phase_hi[TABLE_BITS-1:0];
  assign addr = quad[0] ? (ADDR_W'(N) - {1'b0, fine}) : {1'b0, fine};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r <= ROM[addr];
      neg_r  <= quad[1];
    end
  end

  // Lower half of the cycle is negative
  assign mag  = $signed({1'b0, data_r});
  assign sine = neg_r ? -mag : mag;

endmodule

FILE: hw/rtl/pmv_checker.sv
// Port-level checker for the phase modulation voice, bound to the top level.
`include "phase_modulation_voice_top_macros.svh"

module pmv_checker import pmv_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_sample
);

  // Result held while the sink stalls
  `PMV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid,
                   "result dropped while stalled")
  `PMV_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_sample),
                   "result changed while stalled")

  // One item in flight: input closes for the following steps after a transfer
  `PMV_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready,
                   !in_ready ##1 !in_ready, "input reopened during processing")

  // A new result only appears at the end of processing, never straight from idle
  `PMV_ASSERT_SAME(a_result_from_item, clk, rst_n, $rose(out_valid), !$past(in_ready),
                   "result appeared without processing")

endmodule

bind phase_modulation_voice_top pmv_checker u_pmv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_sample (out_ch.out_sample)
);

FILE: test/phase_modulation_voice_top_tb.sv
// Self-checking testbench for the phase modulation voice: random stimulus, scoreboard.
module phase_modulation_voice_top_tb import pmv_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_BITS = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int QW_LEN = (1 << TABLE_BITS) + 1;
  localparam longint AMPLITUDE = (64'sd1 << (SAMPLE_BITS - 1)) - 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_FIRST = 3'd5;
  localparam int PHASE_ITEMS = 145;

  typedef struct packed {
    logic [SAMPLE_W-1:0] carrier;
    logic [SAMPLE_W-1:0] modulator;
    logic [SAMPLE_W-1:0] ctl_car;
    logic [SAMPLE_W-1:0] ctl_mod;
    logic [SAMPLE_W-1:0] ctl_idx;
    logic [SAMPLE_W-1:0] ctl_frq;
  } voice_item_t;

  // Mirror of the voice: registers, phase and the queue of predicted samples
  class voice_scoreboard;
    logic [GAIN_W-1:0]   car_gain_reg;
    logic [GAIN_W-1:0]   mod_gain_reg;
    logic [INDEX_W-1:0]  mod_index_reg;
    logic [PSTEP_W-1:0]  base_step_reg;
    logic [PSTEP_W-1:0]  min_step_reg;
    logic [PHASE_W-1:0]  phase_acc;
    longint              quarter_wave[QW_LEN];
    logic [SAMPLE_W-1:0] expected_samples[$];
    int                  errors;
    int                  inputs;
    int                  checked;

    function new();
      car_gain_reg  = RST_CARRIER_GAIN;
      mod_gain_reg  = RST_MODULATOR_GAIN;
      mod_index_reg = RST_MOD_INDEX;
      base_step_reg = RST_BASE_STEP;
      min_step_reg  = RST_MIN_STEP;
      phase_acc     = '0;
      errors        = 0;
      inputs        = 0;
      checked       = 0;
      build_quarter_wave();
    endfunction

    // Quarter-wave table: Taylor series in Q30, each term floored, rounded half up
    function void build_quarter_wave();
      logic [63:0] x;
      logic [63:0] term;
      longint      acc;
      for (int k = 0; k < QW_LEN; k++) begin
        x    = (PI_HALF_Q30 * 64'(k)) >> TABLE_BITS;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 13; n++) begin
          term = (((term * x) >> 30) * x) >> 30;
          term = term / (64'(2 * n) * 64'(2 * n + 1));
          if (n % 2 == 1) begin
            acc -= longint'(term);
          end else begin
            acc += longint'(term);
          end
        end
        if (acc < 0) begin
          acc = 0;
        end
        quarter_wave[k] = (acc * AMPLITUDE + (64'sd1 << 29)) >>> 30;
      end
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CARRIER_GAIN:   car_gain_reg  = data[GAIN_W-1:0];
        CFG_MODULATOR_GAIN: mod_gain_reg  = data[GAIN_W-1:0];
        CFG_MOD_INDEX:      mod_index_reg = data[INDEX_W-1:0];
        CFG_BASE_STEP:      base_step_reg = data[PSTEP_W-1:0];
        CFG_MIN_STEP:       min_step_reg  = data[PSTEP_W-1:0];
        default: ;
      endcase
    endfunction

    // Register plus twice the control, held to 0..65535
    function longint apply_gain_ctl(logic [GAIN_W-1:0] base, int ctl);
      longint g;
      g = longint'(base) + 2 * longint'(ctl);
      if (g < 0) begin
        g = 0;
      end
      if (g > 65535) begin
        g = 65535;
      end
      return g;
    endfunction

    // Work out the sample for one transfer and advance the phase
    function void predict_sample(voice_item_t it);
      int             c_idx;
      int             c_frq;
      longint         cg;
      longint         mg;
      longint         idx;
      longint         step;
      longint         car;
      longint         md;
      longint         off;
      longint         sine;
      longint         y;
      logic [PHASE_W-1:0] ph;
      logic [1:0]     quad;
      int             ti;
      c_idx = $signed(it.ctl_idx);
      c_frq = $signed(it.ctl_frq);
      cg = apply_gain_ctl(car_gain_reg, $signed(it.ctl_car));
      mg = apply_gain_ctl(mod_gain_reg, $signed(it.ctl_mod));

      idx = (longint'(mod_index_reg) * longint'(32768 + c_idx)) >>> 15;
      if (idx < longint'(MIN_INDEX)) begin
        idx = longint'(MIN_INDEX);
      end
      if (idx > longint'(MAX_INDEX)) begin
        idx = longint'(MAX_INDEX);
      end

      // upper bound last: it wins over a min step above it
      step = (longint'(base_step_reg) * longint'(32768 + c_frq)) >>> 15;
      if (step < longint'(min_step_reg)) begin
        step = longint'(min_step_reg);
      end
      if (step > longint'(MAX_STEP)) begin
        step = longint'(MAX_STEP);
      end

      car = (longint'($signed(it.carrier)) * cg) >>> 16;
      md  = (longint'($signed(it.modulator)) * mg) >>> 16;
      off = (idx * md * longint'(INV_TWO_PI)) >>> 27;
      ph  = phase_acc + off[PHASE_W-1:0];

      quad = ph[31:30];
      ti   = int'(ph[29:30-TABLE_BITS]);
      sine = quad[0] ? quarter_wave[(1 << TABLE_BITS) - ti] : quarter_wave[ti];
      if (quad[1]) begin
        sine = -sine;
      end

      y = (car * sine) >>> (SAMPLE_BITS - 1);
      if (y > 32767) begin
        y = 32767;
      end
      if (y < -32768) begin
        y = -32768;
      end

      phase_acc = phase_acc + step[PHASE_W-1:0];
      expected_samples.push_back(y[SAMPLE_W-1:0]);
      inputs++;
    endfunction

    function void check_sample(logic [SAMPLE_W-1:0] actual);
      logic [SAMPLE_W-1:0] want;
      if (expected_samples.size() == 0) begin
        $display("%0t: out_sample %0d with no prediction pending", $time, $signed(actual));
        errors++;
      end else begin
        want = expected_samples.pop_front();
        checked++;
        if (want !== actual) begin
          $display("%0t: out_sample expected %0d actual %0d", $time,
                   $signed(want), $signed(actual));
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pmv_in_if  in_ch ();
  pmv_out_if out_ch ();

  voice_scoreboard sb;
  voice_item_t     stim_q[$];
  int              settings_run;

  phase_modulation_voice_top #(
    .SINE_TABLE_BITS(TABLE_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Monitor: note input transfers, check result transfers
  always @(posedge clk) begin
    voice_item_t seen;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_sample(out_ch.out_sample);
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.carrier   = in_ch.carrier_sample;
        seen.modulator = in_ch.modulator_sample;
        seen.ctl_car   = in_ch.ctl_carrier_gain;
        seen.ctl_mod   = in_ch.ctl_modulator_gain;
        seen.ctl_idx   = in_ch.ctl_index;
        seen.ctl_frq   = in_ch.ctl_frequency;
        sb.predict_sample(seen);
      end
    end
  end

  // Receiver: alternating ready runs and stalls of random length
  initial begin
    int  run_left;
    bit  stalling;
    run_left = 0;
    stalling = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        stalling = ($urandom_range(0, 3) == 0);
        run_left = stalling ? $urandom_range(1, 8) : $urandom_range(1, 40);
      end
      out_ch.ready = !stalling;
      run_left--;
    end
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("run did not complete in time");
    $display("FAILURE");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] edge_value();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'h0001;
    endcase
  endfunction

  function automatic voice_item_t make_item(int car, int md, int cc, int cm, int ci, int cf);
    voice_item_t it;
    it.carrier   = 16'(car);
    it.modulator = 16'(md);
    it.ctl_car   = 16'(cc);
    it.ctl_mod   = 16'(cm);
    it.ctl_idx   = 16'(ci);
    it.ctl_frq   = 16'(cf);
    return it;
  endfunction

  // Mostly full-range values, some with idle controls, some at the field edges
  function automatic voice_item_t random_item();
    voice_item_t it;
    it = make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    case ($urandom_range(0, 9))
      0, 1: begin
        it.ctl_car = '0;
        it.ctl_mod = '0;
        it.ctl_idx = '0;
        it.ctl_frq = '0;
      end
      2: begin
        it.carrier   = edge_value();
        it.modulator = edge_value();
        it.ctl_car   = edge_value();
        it.ctl_mod   = edge_value();
        it.ctl_idx   = edge_value();
        it.ctl_frq   = edge_value();
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.write_reg(idx, data);
  endtask

  // Sender: bursts of back-to-back transfers separated by random gaps
  task automatic send_queue();
    voice_item_t it;
    int          burst;
    burst = 0;
    while (stim_q.size() != 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 16);
      end
      it = stim_q.pop_front();
      @(negedge clk);
      in_ch.valid              = 1'b1;
      in_ch.carrier_sample     = it.carrier;
      in_ch.modulator_sample   = it.modulator;
      in_ch.ctl_carrier_gain   = it.ctl_car;
      in_ch.ctl_modulator_gain = it.ctl_mod;
      in_ch.ctl_index          = it.ctl_idx;
      in_ch.ctl_frequency      = it.ctl_frq;
      do @(posedge clk); while (!in_ch.ready);
      burst--;
      if (burst == 0 && $urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
        repeat ($urandom_range(0, 19)) @(negedge clk);
      end
    end
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One register setting: load all registers while idle, then stream random items
  task automatic run_phase(logic [CFG_DATA_W-1:0] cg, logic [CFG_DATA_W-1:0] mg,
                           logic [CFG_DATA_W-1:0] mi, logic [CFG_DATA_W-1:0] bs,
                           logic [CFG_DATA_W-1:0] ms, int n_items);
    drain();
    write_cfg(CFG_CARRIER_GAIN, cg);
    write_cfg(CFG_MODULATOR_GAIN, mg);
    write_cfg(CFG_MOD_INDEX, mi);
    write_cfg(CFG_BASE_STEP, bs);
    write_cfg(CFG_MIN_STEP, ms);
    // unused register slots must leave the voice alone
    if ($urandom_range(0, 2) == 0) begin
      write_cfg(CFG_UNUSED_FIRST + 3'($urandom_range(0, 2)), 31'($urandom));
    end
    @(negedge clk);
    cfg_we = 1'b0;
    repeat (n_items) stim_q.push_back(random_item());
    send_queue();
    settings_run++;
  endtask

  task automatic random_phase(int n_items);
    logic [CFG_DATA_W-1:0] mi;
    logic [CFG_DATA_W-1:0] bs;
    logic [CFG_DATA_W-1:0] ms;
    mi = ($urandom_range(0, 3) != 0) ? 31'($urandom_range(41, 40960))
                                     : 31'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0:       bs = 31'($urandom_range(0, 1 << 26));
      1:       bs = 31'($urandom_range(1, 1932735283));
      2:       bs = 31'($urandom_range(30000000, 50000000));
      default: bs = 31'($urandom);
    endcase
    ms = ($urandom_range(0, 3) != 0) ? 31'($urandom_range(0, 1 << 20)) : 31'($urandom);
    // random bits above the 16-bit registers are dropped by the block
    run_phase({15'($urandom), 16'($urandom)}, {15'($urandom), 16'($urandom)},
              {15'($urandom), mi[15:0]}, bs, ms, n_items);
  endtask

  initial begin
    sb           = new();
    settings_run = 0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid              = 1'b0;
    in_ch.carrier_sample     = '0;
    in_ch.modulator_sample   = '0;
    in_ch.ctl_carrier_gain   = '0;
    in_ch.ctl_modulator_gain = '0;
    in_ch.ctl_index          = '0;
    in_ch.ctl_frequency      = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items on the reset settings: field extremes and control saturation
    stim_q.push_back(make_item(0, 0, 0, 0, 0, 0));
    stim_q.push_back(make_item(32767, 0, 0, 0, 0, 0));
    stim_q.push_back(make_item(-32768, 0, 0, 0, 0, 0));
    stim_q.push_back(make_item(32767, 32767, 0, 0, 0, 0));
    stim_q.push_back(make_item(-32768, -32768, 0, 0, 0, 0));
    stim_q.push_back(make_item(32767, -32768, 32767, 0, 0, 0));
    stim_q.push_back(make_item(-32768, 32767, -32768, 0, 0, 0));
    stim_q.push_back(make_item(20000, 32767, 0, 32767, 0, 0));
    stim_q.push_back(make_item(20000, 32767, 0, -32768, 0, 0));
    stim_q.push_back(make_item(-20000, 16384, 0, 0, -32768, 0));
    stim_q.push_back(make_item(-20000, 16384, 0, 0, 32767, 0));
    stim_q.push_back(make_item(12345, -12345, 0, 0, 0, -32768));
    stim_q.push_back(make_item(12345, -12345, 0, 0, 0, 32767));
    stim_q.push_back(make_item(32767, 32767, 32767, 32767, 32767, 32767));
    stim_q.push_back(make_item(-32768, -32768, -32768, -32768, -32768, -32768));
    stim_q.push_back(make_item(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    stim_q.push_back(make_item(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    stim_q.push_back(make_item(-1, 1, -1, 1, -1, 1));
    stim_q.push_back(make_item(1, -1, 1, -1, 1, -1));
    stim_q.push_back(make_item(30000, 100, 0, 0, 0, 32767));
    repeat (80) stim_q.push_back(random_item());
    send_queue();
    settings_run++;

    // Zero gains, index below range, zero step with zero minimum: phase holds
    run_phase(31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 100);
    // Top of every register: index above range, minimum above the step ceiling
    run_phase(31'd65535, 31'd65535, 31'd65535, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 100);
    // Bottom of the ranges, but for the modulator gain at its top
    run_phase(31'd0, 31'd65535, 31'(MIN_INDEX), 31'd1, 31'd1, 100);
    // Index and step at their ceilings: phase wraps every few samples
    run_phase(31'd65535, 31'd0, 31'(MAX_INDEX), 31'(MAX_STEP), 31'd895, 100);
    repeat (9) random_phase(PHASE_ITEMS);

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d input transfers and %0d checked samples over %0d register settings",
             sb.inputs, sb.checked, settings_run);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d predictions left", sb.errors, sb.pending());
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: phase_modulation_voice_top.f
+incdir+hw/rtl
hw/rtl/pmv_pkg.sv
hw/rtl/pmv_if.sv
hw/rtl/pmv_seq.sv
hw/rtl/pmv_sine_rom.sv
hw/rtl/phase_modulation_voice_top.sv
hw/rtl/pmv_checker.sv
test/phase_modulation_voice_top_tb.sv
